// ----- src/rjd_pkg.sv -----
package rjd_pkg;

   localparam int DELAY_W    = 48;
   localparam int WORD_W     = 64;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;
   localparam int SCALE_W    = 32;
   localparam int MODE_W     = 2;
   localparam int T_W        = 42;
   localparam int NORM_W     = 54;
   localparam int EXP_W      = 6;

   localparam logic [63:0] GOLDEN  = 64'h9E3779B97F4A7C15;
   localparam logic [63:0] MIX_C1  = 64'hBF58476D1CE4E5B9;
   localparam logic [63:0] MIX_C2  = 64'h94D049BB133111EB;
   localparam logic [63:0] LN2_Q32 = 64'd2977044472;
   localparam logic [63:0] K_1000  = 64'd1000;
   localparam logic [EXP_W-1:0] TOP_EXP = 6'd53;
   localparam logic [DELAY_W-1:0] DELAY_MAX = {DELAY_W{1'b1}};

   localparam logic [CSR_IDX_W-1:0] CSR_SEED  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE = 2'd2;

   localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_UNI  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_EXP  = 2'd2;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_MUL,
      OP_TAKE_T,
      OP_ADV,
      OP_TAKE27,
      OP_TAKE31,
      OP_NINIT,
      OP_NSTEP,
      OP_MANT,
      OP_SQT,
      OP_LNT,
      OP_OUT_U,
      OP_OUT_E,
      OP_OUT_NONE
   } op_type;

   typedef enum logic [2:0] {
      MS_T,
      MS_C1,
      MS_C2,
      MS_RT,
      MS_SQ,
      MS_LN2,
      MS_TLN
   } mul_sel_type;

   typedef struct packed {
      op_type      op;
      mul_sel_type mul_sel;
      logic [1:0]  step;
   } dp_cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              norm_done;
   } dp_status_type;

endpackage

// ----- src/rjd_if.sv -----
interface rjd_req_if;
   import rjd_pkg::*;
   logic valid;
   logic ready;
   logic request;
   modport source(output valid, output request, input ready);
   modport sink(input valid, input request, output ready);
endinterface

interface rjd_rsp_if;
   import rjd_pkg::*;
   logic               valid;
   logic               ready;
   logic [DELAY_W-1:0] delay_ns;
   logic [WORD_W-1:0]  random_word;
   modport source(output valid, output delay_ns, output random_word, input ready);
   modport sink(input valid, input delay_ns, input random_word, output ready);
endinterface

// ----- src/random_jitter_delay_generator.sv -----
// Jitter delay generator. Each request beat on req_ch yields one beat on
// rsp_ch carrying delay_ns (Q32.16 ns, saturating) and the splitmix64 word.
// A request beat with request low yields no result.
// Registers on the csr_ port: 0 seed (reloads the generator), 1 mode
// (0 none, 1 uniform, 2 exponential; 3 acts as none), 2 scale (Q16.16 us).
// Write them only while idle; a write takes effect at the next edge.
// One item at a time: req_ch.ready is high only while the sequencer is idle.
// Mode none publishes a zero delay and word; uniform and exponential items
// first step the generator, and exponential adds a normalize of 2^53 - r
// (r = top 53 bits of the word) and a log loop. The sequencer returns to
// idle after each item. The work time is set by the one shared 32x32
// multiplier (four partial products per wide product), the one-bit-a-cycle
// normalize and one squaring per log bit.
// When rsp_ch stalls, the finished beat is held in the output register and
// the next item may be accepted and worked; it waits only to publish.
// Synchronous reset clears mode, scale and generator state to zero and
// drops rsp valid.
module random_jitter_delay_generator #(
   parameter int TAIL_CAP      = 8,
   parameter int LOG_FRAC_BITS = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   rjd_req_if.sink                        req_ch,
   rjd_rsp_if.source                      rsp_ch,
   input  logic                           csr_we,
   input  logic [rjd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rjd_pkg::CSR_DATA_W-1:0] csr_data
);
   import rjd_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   rjd_controller #(.LOG_FRAC_BITS(LOG_FRAC_BITS)) u_ctl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_request (req_ch.request),
      .req_ready   (req_ch.ready),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .status      (status),
      .cmd         (cmd)
   );

   rjd_datapath #(.TAIL_CAP(TAIL_CAP), .LOG_FRAC_BITS(LOG_FRAC_BITS)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .delay_ns    (rsp_ch.delay_ns),
      .random_word (rsp_ch.random_word)
   );

endmodule

// ----- src/rjd_datapath.sv -----
module rjd_datapath #(
   parameter int TAIL_CAP      = 8,
   parameter int LOG_FRAC_BITS = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rjd_pkg::dp_cmd_type                 cmd,
   output rjd_pkg::dp_status_type              status,
   input  logic                                csr_we,
   input  logic [rjd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rjd_pkg::CSR_DATA_W-1:0]      csr_data,
   output logic [rjd_pkg::DELAY_W-1:0]         delay_ns,
   output logic [rjd_pkg::WORD_W-1:0]          random_word
);
   import rjd_pkg::*;

   localparam int LNW = LOG_FRAC_BITS + 6;
   localparam logic [LNW-1:0] CAP = LNW'(TAIL_CAP) << LOG_FRAC_BITS;

   logic [63:0]            state_ff, z_ff, state_in;
   logic [T_W-1:0]         t_ff;
   logic [127:0]           acc_ff, acc_in, shifted;
   logic [NORM_W-1:0]      norm_ff;
   logic [EXP_W-1:0]       e_ff;
   logic [31:0]            x_ff, sq_y;
   logic [LOG_FRAC_BITS-1:0] frac_ff;
   logic [LNW-1:0]         ln_ff, ln_raw, nl2;
   logic [MODE_W-1:0]      mode_ff;
   logic [SCALE_W-1:0]     scale_ff;
   logic [DELAY_W-1:0]     delay_ff;
   logic [WORD_W-1:0]      word_ff;
   logic [63:0]            op_a, op_b, lo, pp;
   logic [31:0]            a_half, b_half;

   assign nl2    = (LNW'(TOP_EXP - e_ff) << LOG_FRAC_BITS) - LNW'(frac_ff);
   assign ln_raw = acc_ff[LNW+31:32];
   assign sq_y   = acc_ff[61:30];
   assign lo     = acc_ff[63:0];
   assign state_in = state_ff + GOLDEN;

   always_comb begin
      case (cmd.mul_sel)
         MS_T:    begin op_a = 64'(scale_ff); op_b = K_1000;     end
         MS_C1:   begin op_a = z_ff;          op_b = MIX_C1;     end
         MS_C2:   begin op_a = z_ff;          op_b = MIX_C2;     end
         MS_RT:   begin op_a = 64'(z_ff[63:11]); op_b = 64'(t_ff); end
         MS_SQ:   begin op_a = 64'(x_ff);     op_b = 64'(x_ff);  end
         MS_LN2:  begin op_a = 64'(nl2);      op_b = LN2_Q32;    end
         MS_TLN:  begin op_a = 64'(t_ff);     op_b = 64'(ln_ff); end
         default: begin op_a = '0;            op_b = '0;         end
      endcase
   end

   assign a_half = cmd.step[1] ? op_a[63:32] : op_a[31:0];
   assign b_half = cmd.step[0] ? op_b[63:32] : op_b[31:0];
   assign pp     = {32'b0, a_half} * {32'b0, b_half};

   always_comb begin
      case (cmd.step)
         2'd0:    shifted = {64'b0, pp};
         2'd3:    shifted = {pp, 64'b0};
         default: shifted = {32'b0, pp, 32'b0};
      endcase
      acc_in = ((cmd.step == 2'd0) ? 128'b0 : acc_ff) + shifted;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         mode_ff  <= MODE_NONE;
         scale_ff <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SEED:  state_ff <= csr_data;
               CSR_MODE:  mode_ff  <= csr_data[MODE_W-1:0];
               CSR_SCALE: scale_ff <= csr_data[SCALE_W-1:0];
               default:   ;
            endcase
         end
         if (cmd.op == OP_ADV) state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_MUL:    acc_ff <= acc_in;
         OP_TAKE_T: t_ff <= acc_ff[T_W-1:0];
         OP_ADV:    z_ff <= state_in ^ (state_in >> 30);
         OP_TAKE27: z_ff <= lo ^ (lo >> 27);
         OP_TAKE31: z_ff <= lo ^ (lo >> 31);
         OP_NINIT: begin
            norm_ff <= (NORM_W'(1) << 53) - {1'b0, z_ff[63:11]};
            e_ff    <= TOP_EXP;
         end
         OP_NSTEP: begin
            if (!norm_ff[NORM_W-1]) begin
               norm_ff <= norm_ff << 1;
               e_ff    <= e_ff - 6'd1;
            end
         end
         OP_MANT: begin
            x_ff    <= {1'b0, norm_ff[53:23]};
            frac_ff <= '0;
         end
         OP_SQT: begin
            frac_ff <= {frac_ff[LOG_FRAC_BITS-2:0], sq_y[31]};
            x_ff    <= sq_y[31] ? {1'b0, sq_y[31:1]} : sq_y;
         end
         OP_LNT:    ln_ff <= (ln_raw > CAP) ? CAP : ln_raw;
         OP_OUT_U: begin
            delay_ff <= (|acc_ff[127:101]) ? DELAY_MAX : acc_ff[100:53];
            word_ff  <= z_ff;
         end
         OP_OUT_E: begin
            delay_ff <= (|acc_ff[127:LOG_FRAC_BITS+DELAY_W]) ? DELAY_MAX :
                        acc_ff[LOG_FRAC_BITS+DELAY_W-1:LOG_FRAC_BITS];
            word_ff  <= z_ff;
         end
         OP_OUT_NONE: begin
            delay_ff <= '0;
            word_ff  <= '0;
         end
         default: ;
      endcase
   end

   assign status.mode      = mode_ff;
   assign status.norm_done = norm_ff[NORM_W-1];
   assign delay_ns    = delay_ff;
   assign random_word = word_ff;

endmodule

// ----- src/rjd_controller.sv -----
module rjd_controller #(
   parameter int LOG_FRAC_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_request,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rjd_pkg::dp_status_type status,
   output rjd_pkg::dp_cmd_type    cmd
);
   import rjd_pkg::*;

   localparam int CW = $clog2(LOG_FRAC_BITS + 1);

   typedef enum logic [4:0] {
      S_IDLE, S_TMUL, S_TTAKE, S_ADV, S_MIX1, S_TAKE1, S_MIX2, S_TAKE2,
      S_RT, S_OUTU, S_NINIT, S_NSTEP, S_MANT, S_SQ, S_SQT, S_LN2, S_LNT,
      S_TLN, S_OUTE, S_OUTN
   } state_type;

   state_type     state_ff;
   logic [1:0]    step_ff;
   logic [CW-1:0] cnt_ff;
   logic          rsp_valid_ff;
   logic          out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.op      = OP_NONE;
      cmd.mul_sel = MS_T;
      cmd.step    = step_ff;
      case (state_ff)
         S_TMUL:  begin cmd.op = OP_MUL; cmd.mul_sel = MS_T;   end
         S_TTAKE: cmd.op = OP_TAKE_T;
         S_ADV:   cmd.op = OP_ADV;
         S_MIX1:  begin cmd.op = OP_MUL; cmd.mul_sel = MS_C1;  end
         S_TAKE1: cmd.op = OP_TAKE27;
         S_MIX2:  begin cmd.op = OP_MUL; cmd.mul_sel = MS_C2;  end
         S_TAKE2: cmd.op = OP_TAKE31;
         S_RT:    begin cmd.op = OP_MUL; cmd.mul_sel = MS_RT;  end
         S_NINIT: cmd.op = OP_NINIT;
         S_NSTEP: cmd.op = OP_NSTEP;
         S_MANT:  cmd.op = OP_MANT;
         S_SQ:    begin cmd.op = OP_MUL; cmd.mul_sel = MS_SQ; cmd.step = 2'd0; end
         S_SQT:   cmd.op = OP_SQT;
         S_LN2:   begin cmd.op = OP_MUL; cmd.mul_sel = MS_LN2; end
         S_LNT:   cmd.op = OP_LNT;
         S_TLN:   begin cmd.op = OP_MUL; cmd.mul_sel = MS_TLN; end
         S_OUTU:  if (out_free) cmd.op = OP_OUT_U;
         S_OUTE:  if (out_free) cmd.op = OP_OUT_E;
         S_OUTN:  if (out_free) cmd.op = OP_OUT_NONE;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               step_ff <= '0;
               if (req_valid && req_request) begin
                  if (status.mode == MODE_UNI || status.mode == MODE_EXP)
                     state_ff <= S_TMUL;
                  else
                     state_ff <= S_OUTN;
               end
            end
            S_TMUL, S_MIX1, S_MIX2, S_RT, S_LN2, S_TLN: begin
               step_ff <= step_ff + 2'd1;
               if (step_ff == 2'd3) begin
                  case (state_ff)
                     S_TMUL:  state_ff <= S_TTAKE;
                     S_MIX1:  state_ff <= S_TAKE1;
                     S_MIX2:  state_ff <= S_TAKE2;
                     S_RT:    state_ff <= S_OUTU;
                     S_LN2:   state_ff <= S_LNT;
                     default: state_ff <= S_OUTE;
                  endcase
               end
            end
            S_TTAKE: state_ff <= S_ADV;
            S_ADV:   state_ff <= S_MIX1;
            S_TAKE1: state_ff <= S_MIX2;
            S_TAKE2: state_ff <= (status.mode == MODE_UNI) ? S_RT : S_NINIT;
            S_NINIT: state_ff <= S_NSTEP;
            S_NSTEP: if (status.norm_done) state_ff <= S_MANT;
            S_MANT: begin
               cnt_ff   <= '0;
               state_ff <= S_SQ;
            end
            S_SQ:    state_ff <= S_SQT;
            S_SQT: begin
               cnt_ff <= cnt_ff + CW'(1);
               if (cnt_ff == CW'(LOG_FRAC_BITS - 1)) state_ff <= S_LN2;
               else state_ff <= S_SQ;
            end
            S_LNT:   state_ff <= S_TLN;
            S_OUTU, S_OUTE, S_OUTN: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
